// ===== sv/pphit_pkg.sv =====
// ----------------------------------------------------------------------------
// pphit_pkg: shared types and constants of the polygon point hit test
// Command and result item layouts, op codes, sequencer states and the
// operand selects of the shared side-of-line unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pphit_pkg;

	// Coordinate width of the command fields
	localparam int COORD_W = 16;

	// Op codes of the command item
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEST   = 2'd2;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic overflow;
	} res_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_LD_B,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_E6,
		ST_CHK,
		ST_W_LD,
		ST_W_E1,
		ST_W_E2,
		ST_W_CK
	} state_t;

	// Operand select of the side-of-line unit: point, line start, line end.
	// A and B are the current edge's vertices, O is the box center, P the point.
	typedef enum logic [2:0] {
		EV_P_AB,
		EV_O_AB,
		EV_P_BO,
		EV_A_BO,
		EV_P_OA,
		EV_B_OA
	} ev_sel_t;

endpackage

`default_nettype wire

// ===== sv/polygon_point_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// polygon_point_hit_test_top: convex polygon point hit test
// Vertex store with bounding box, and a sequenced edge walk that tests a
// point against the edges in turn through one shared side-of-line unit.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: item is taken on a rising edge where start is high and
//   busy is low. op selects clear, append vertex or test point.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver takes every result, there is no back pressure.
//   Clear produces no result; unused op code 3 is ignored.
//   Append: result (hit 0, overflow set if the store was full) shows up the
//   cycle after the transfer; busy stays low, so commands may stream.
//   Test: busy goes high for the walk. With n stored vertices the result
//   comes at the check of the remembered edge when that edge decides it,
//   and otherwise when a further edge shows a miss or all edges are walked. An
//   empty polygon answers on the next cycle. The walk is paced by the
//   vertex memory's single read port and the one shared side-of-line unit:
//   each further edge costs one read, a load, and two side evaluations
//   (point and box center).
//   Reset: vertex count, bounding box, remembered edge and the sequencer go
//   to zero/idle at once; vertex memory contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_point_hit_test_top #(
	parameter int MAX_VERTICES = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire pphit_pkg::in_item_t item,
	output logic                 done,
	output pphit_pkg::res_item_t result
);
	import pphit_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);       // vertex index
	localparam int CW = $clog2(MAX_VERTICES + 1);   // vertex count
	localparam int DV = COORD_W + 1;                // doubled coordinate
	localparam int DW = COORD_W + 2;                // difference of doubled values
	localparam int PW = 2 * DW;                     // product
	localparam int SW = PW + 1;                     // sum of two products

	// Vertex store, read through one registered port
	logic signed [COORD_W-1:0] vx_mem [MAX_VERTICES];
	logic signed [COORD_W-1:0] vy_mem [MAX_VERTICES];
	logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0]             rd_addr;

	// Polygon state
	logic [CW-1:0]             count_q;
	logic signed [COORD_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [AW-1:0]             lfe_q;

	// Sequencer
	state_t                    state_q, state_d;
	logic [AW-1:0]             idx_q, idx1_q;
	logic [CW-1:0]             cnt_q;
	logic                      dir_q;
	logic [4:0]                sg_q;
	logic                      sgp_q;

	// Test operands: doubled point, doubled center, current edge vertices
	logic signed [DV-1:0]      px_q, py_q, ox_q, oy_q;
	logic signed [COORD_W-1:0] va_x_q, va_y_q, vb_x_q, vb_y_q;

	// Shared side-of-line unit
	ev_sel_t                   ev_sel;
	logic signed [DV-1:0]      ev_px, ev_py, ev_ax, ev_ay, ev_bx, ev_by;
	logic signed [DV-1:0]      va2_x, va2_y, vb2_x, vb2_y;
	logic signed [DW-1:0]      na, nb, dx, dy;
	logic signed [PW-1:0]      prod_a_s1, prod_b_s1;
	logic signed [SW-1:0]      ev_sum;
	logic                      sgn;

	// Control
	logic                      accept, full;
	logic                      fin, fin_hit, adv, adv_dir, lfe_we;
	logic                      edge_ok, wedge_s, wedge_w;
	logic                      done_q;
	res_item_t                 result_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i,
			input logic [CW-1:0] n);
		return ((CW'(i) + CW'(1)) == n) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i,
			input logic [CW-1:0] n);
		return (i == '0) ? AW'(n - CW'(1)) : i - AW'(1);
	endfunction

	assign accept = start && !busy;
	assign full   = (count_q == CW'(MAX_VERTICES));
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// ---------------------------------------------------------------- unit
	assign va2_x = {va_x_q, 1'b0};
	assign va2_y = {va_y_q, 1'b0};
	assign vb2_x = {vb_x_q, 1'b0};
	assign vb2_y = {vb_y_q, 1'b0};

	always_comb begin
		ev_px = px_q;
		ev_py = py_q;
		ev_ax = va2_x;
		ev_ay = va2_y;
		ev_bx = vb2_x;
		ev_by = vb2_y;
		case (ev_sel)
			EV_P_AB: begin
			end
			EV_O_AB: begin
				ev_px = ox_q;
				ev_py = oy_q;
			end
			EV_P_BO: begin
				ev_ax = vb2_x;
				ev_ay = vb2_y;
				ev_bx = ox_q;
				ev_by = oy_q;
			end
			EV_A_BO: begin
				ev_px = va2_x;
				ev_py = va2_y;
				ev_ax = vb2_x;
				ev_ay = vb2_y;
				ev_bx = ox_q;
				ev_by = oy_q;
			end
			EV_P_OA: begin
				ev_ax = ox_q;
				ev_ay = oy_q;
				ev_bx = va2_x;
				ev_by = va2_y;
			end
			EV_B_OA: begin
				ev_px = vb2_x;
				ev_py = vb2_y;
				ev_ax = ox_q;
				ev_ay = oy_q;
				ev_bx = va2_x;
				ev_by = va2_y;
			end
			default: begin
			end
		endcase
	end

	// Normal (ay-by, bx-ax) dotted with (p-a); products registered, sign taken from their sum
	assign na = {ev_ay[DV-1], ev_ay} - {ev_by[DV-1], ev_by};
	assign nb = {ev_bx[DV-1], ev_bx} - {ev_ax[DV-1], ev_ax};
	assign dx = {ev_px[DV-1], ev_px} - {ev_ax[DV-1], ev_ax};
	assign dy = {ev_py[DV-1], ev_py} - {ev_ay[DV-1], ev_ay};

	always_ff @(posedge clk) begin
		prod_a_s1 <= na * dx;
		prod_b_s1 <= nb * dy;
	end

	assign ev_sum = {prod_a_s1[PW-1], prod_a_s1} + {prod_b_s1[PW-1], prod_b_s1};
	assign sgn    = !ev_sum[SW-1];

	// Remembered edge and its wedge, decided in ST_CHK
	assign edge_ok = (sg_q[4] == sg_q[3]);
	assign wedge_s = (sg_q[2] == sg_q[1]);
	assign wedge_w = (sg_q[0] == sgn);

	// ----------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q;
		ev_sel  = EV_P_AB;
		fin     = 1'b0;
		fin_hit = 1'b0;
		adv     = 1'b0;
		adv_dir = dir_q;
		lfe_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.op == OP_TEST && count_q != '0) begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				rd_addr = idx_q;
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				rd_addr = idx1_q;
				state_d = ST_LD_B;
			end
			ST_LD_B: state_d = ST_E1;
			ST_E1: begin
				ev_sel  = EV_P_AB;
				state_d = ST_E2;
			end
			ST_E2: begin
				ev_sel  = EV_O_AB;
				state_d = ST_E3;
			end
			ST_E3: begin
				ev_sel  = EV_P_BO;
				state_d = ST_E4;
			end
			ST_E4: begin
				ev_sel  = EV_A_BO;
				state_d = ST_E5;
			end
			ST_E5: begin
				ev_sel  = EV_P_OA;
				state_d = ST_E6;
			end
			ST_E6: begin
				ev_sel  = EV_B_OA;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				adv_dir = wedge_s;
				if (!edge_ok) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if ((wedge_s && wedge_w) || count_q == CW'(1)) begin
					fin     = 1'b1;
					fin_hit = 1'b1;
					state_d = ST_IDLE;
				end else begin
					adv     = 1'b1;
					state_d = ST_W_LD;
				end
			end
			ST_W_LD: state_d = ST_W_E1;
			ST_W_E1: begin
				ev_sel  = EV_P_AB;
				state_d = ST_W_E2;
			end
			ST_W_E2: begin
				ev_sel  = EV_O_AB;
				state_d = ST_W_CK;
			end
			ST_W_CK: begin
				if (sgp_q != sgn) begin
					fin     = 1'b1;
					lfe_we  = 1'b1;
					state_d = ST_IDLE;
				end else if (cnt_q == count_q - CW'(1)) begin
					fin     = 1'b1;
					fin_hit = 1'b1;
					state_d = ST_IDLE;
				end else begin
					adv     = 1'b1;
					state_d = ST_W_LD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// Step to the next edge: fetch the one vertex it does not share
		if (adv) begin
			rd_addr = adv_dir ? wrap_inc(idx1_q, count_q) : wrap_dec(idx_q, count_q);
		end
	end

	// -------------------------------------------------------- polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			lfe_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			// Strobe a result for an append, for a test of an empty polygon
			// (a miss at once), and at the end of a walk
			done_q <= fin || (accept && (item.op == OP_APPEND ||
				(item.op == OP_TEST && count_q == '0)));
			if (accept) begin
				case (item.op)
					OP_CLEAR: begin
						count_q  <= '0;
						left_q   <= '0;
						right_q  <= '0;
						top_q    <= '0;
						bottom_q <= '0;
						lfe_q    <= '0;
					end
					OP_APPEND: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
							if (count_q == '0) begin
								left_q   <= item.coord_x;
								right_q  <= item.coord_x;
								top_q    <= item.coord_y;
								bottom_q <= item.coord_y;
							end else begin
								if (item.coord_x < left_q)   left_q   <= item.coord_x;
								if (item.coord_x > right_q)  right_q  <= item.coord_x;
								if (item.coord_y > top_q)    top_q    <= item.coord_y;
								if (item.coord_y < bottom_q) bottom_q <= item.coord_y;
							end
						end
					end
					default: begin
					end
				endcase
			end
			// Remember the edge that separated the point from the center
			if (lfe_we) lfe_q <= idx_q;
		end
	end

	// ------------------------------------------------------------ datapath
	always_ff @(posedge clk) begin
		if (accept && item.op == OP_APPEND && !full) begin
			vx_mem[count_q[AW-1:0]] <= item.coord_x;
			vy_mem[count_q[AW-1:0]] <= item.coord_y;
		end
		rd_x_q <= vx_mem[rd_addr];
		rd_y_q <= vy_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (item.op)
				OP_APPEND: result_q <= '{hit: 1'b0, overflow: full};
				OP_TEST:   result_q <= '{hit: 1'b0, overflow: 1'b0};
				default: begin
				end
			endcase
		end
		if (fin) result_q <= '{hit: fin_hit, overflow: 1'b0};
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_TEST) begin
			// Remembered edge is below any nonzero count: clear zeroes both,
			// and the count only grows between clears.
			px_q   <= {item.coord_x, 1'b0};
			py_q   <= {item.coord_y, 1'b0};
			ox_q   <= {left_q[COORD_W-1], left_q} + {right_q[COORD_W-1], right_q};
			oy_q   <= {bottom_q[COORD_W-1], bottom_q} + {top_q[COORD_W-1], top_q};
			idx_q  <= lfe_q;
			idx1_q <= wrap_inc(lfe_q, count_q);
		end
		if (state_q == ST_RD_B) begin
			va_x_q <= rd_x_q;
			va_y_q <= rd_y_q;
		end
		if (state_q == ST_LD_B) begin
			vb_x_q <= rd_x_q;
			vb_y_q <= rd_y_q;
		end
		if (state_q == ST_E2 || state_q == ST_E3 || state_q == ST_E4 ||
				state_q == ST_E5 || state_q == ST_E6) begin
			sg_q <= {sg_q[3:0], sgn};
		end
		if (state_q == ST_W_E2) sgp_q <= sgn;
		if (state_q == ST_CHK) begin
			dir_q <= wedge_s;
			cnt_q <= CW'(1);
		end
		if (state_q == ST_W_CK && adv) cnt_q <= cnt_q + CW'(1);
		if (adv) begin
			if (adv_dir) begin
				idx_q  <= idx1_q;
				idx1_q <= wrap_inc(idx1_q, count_q);
				va_x_q <= vb_x_q;
				va_y_q <= vb_y_q;
			end else begin
				idx1_q <= idx_q;
				idx_q  <= wrap_dec(idx_q, count_q);
				vb_x_q <= va_x_q;
				vb_y_q <= va_y_q;
			end
		end
		if (state_q == ST_W_LD) begin
			if (dir_q) begin
				vb_x_q <= rd_x_q;
				vb_y_q <= rd_y_q;
			end else begin
				va_x_q <= rd_x_q;
				va_y_q <= rd_y_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/pphit_check.sv =====
// ----------------------------------------------------------------------------
// pphit_check: port-level checks of the polygon point hit test
// Watches command transfers and result strobes on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pphit_check (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input wire pphit_pkg::in_item_t  item,
	input wire                  done,
	input wire pphit_pkg::res_item_t result
);
	import pphit_pkg::*;

	logic xfer;
	assign xfer = start && !busy;

	// Results only leave while the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Clear and the unused code produce no result
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && item.op != OP_APPEND && item.op != OP_TEST) |=> !done)
		else $error("result after clear or unused op");

	// Append answers on the next cycle and never reports a hit
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && item.op == OP_APPEND) |=> (done && !result.hit))
		else $error("append result missing or wrong");

	// Test either answers at once (empty polygon) or starts a walk
	a_test: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && item.op == OP_TEST) |=> (done != busy))
		else $error("test neither answered nor started");

endmodule

bind polygon_point_hit_test_top pphit_check u_pphit_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire
